// ----- design/msk_pkg.sv -----
// msk_pkg: shared types and constants for the max-tracking stack engine
// used by msk_ctrl, msk_dp and max_stack_engine; depends on nothing else
package msk_pkg;

    // default stack depth, handed to the top level as its parameter default
    localparam int MSK_DEPTH_DEF = 1024;

    // fixed field widths
    localparam int VAL_W      = 32;
    localparam int REQ_W      = 2;
    localparam int ST_W       = 2;
    localparam int CNT_OUT_W  = 11;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_PAD_W  = OUT_DATA_W - 3 * VAL_W - CNT_OUT_W;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_POPMAX = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_TOP,
        S_POP_MAXV,
        S_PM_IDX,
        S_PM_VAL,
        S_WALK_RD,
        S_WALK_WR,
        S_RESP
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_PUSH,
        OP_ERR_EMPTY,
        OP_ERR_FULL,
        OP_POP,
        OP_POP_TOP,
        OP_POP_MAXV,
        OP_PM_START,
        OP_PM_IDX,
        OP_PM_VAL,
        OP_WALK_RD,
        OP_WALK_WR
    } t_dp_op;

    // controller to datapath
    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_req req;
        logic empty;
        logic full;
        logic one_left;
        logic max_at_top;
        logic max_pos_zero;
        logic walk_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- design/msk_ctrl.sv -----
// msk_ctrl: sequencing state machine for the max-tracking stack engine
// depends on msk_pkg; drives msk_dp through t_dp_cmd and reads t_dp_stat
module msk_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  msk_pkg::t_dp_stat i_stat,
    output msk_pkg::t_dp_cmd  o_cmd
);
    import msk_pkg::*;

    t_state r_state;
    t_state n_state;
    t_dp_op w_op;
    logic   w_fin;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.out_free ? S_IDLE : S_RESP;
                unique case (i_stat.req)
                    REQ_POP: begin
                        if (!i_stat.empty && !i_stat.one_left) begin
                            n_state = S_POP_TOP;
                        end
                    end
                    REQ_POPMAX: begin
                        if (!i_stat.empty) begin
                            if (i_stat.max_at_top) begin
                                if (!i_stat.one_left) begin
                                    n_state = S_POP_TOP;
                                end
                            end else if (i_stat.max_pos_zero) begin
                                n_state = S_WALK_RD;
                            end else begin
                                n_state = S_PM_IDX;
                            end
                        end
                    end
                    REQ_PUSH, REQ_NONE: begin
                        n_state = i_stat.out_free ? S_IDLE : S_RESP;
                    end
                    default: n_state = i_stat.out_free ? S_IDLE : S_RESP;
                endcase
            end
            S_POP_TOP:  n_state = S_POP_MAXV;
            S_POP_MAXV: n_state = i_stat.out_free ? S_IDLE : S_RESP;
            S_PM_IDX:   n_state = S_PM_VAL;
            S_PM_VAL:   n_state = S_WALK_RD;
            S_WALK_RD:  n_state = S_WALK_WR;
            S_WALK_WR: begin
                if (i_stat.walk_last) begin
                    n_state = i_stat.out_free ? S_IDLE : S_RESP;
                end else begin
                    n_state = S_WALK_RD;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        w_op  = OP_NONE;
        w_fin = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_op = OP_LATCH;
                end
            end
            S_EXEC: begin
                unique case (i_stat.req)
                    REQ_PUSH: begin
                        w_op  = i_stat.full ? OP_ERR_FULL : OP_PUSH;
                        w_fin = 1'b1;
                    end
                    REQ_POP: begin
                        if (i_stat.empty) begin
                            w_op  = OP_ERR_EMPTY;
                            w_fin = 1'b1;
                        end else begin
                            w_op  = OP_POP;
                            w_fin = i_stat.one_left;
                        end
                    end
                    REQ_POPMAX: begin
                        if (i_stat.empty) begin
                            w_op  = OP_ERR_EMPTY;
                            w_fin = 1'b1;
                        end else if (i_stat.max_at_top) begin
                            w_op  = OP_POP;
                            w_fin = i_stat.one_left;
                        end else begin
                            w_op = OP_PM_START;
                        end
                    end
                    REQ_NONE: w_fin = 1'b1;
                    default:  w_fin = 1'b1;
                endcase
            end
            S_POP_TOP: w_op = OP_POP_TOP;
            S_POP_MAXV: begin
                w_op  = OP_POP_MAXV;
                w_fin = 1'b1;
            end
            S_PM_IDX:  w_op = OP_PM_IDX;
            S_PM_VAL:  w_op = OP_PM_VAL;
            S_WALK_RD: w_op = OP_WALK_RD;
            S_WALK_WR: begin
                w_op  = OP_WALK_WR;
                w_fin = i_stat.walk_last;
            end
            S_RESP: w_fin = 1'b1;
            default: w_op = OP_NONE;
        endcase
    end

    assign o_cmd.op       = w_op;
    assign o_cmd.out_load = w_fin && i_stat.out_free;
    assign o_s_tready     = (r_state == S_IDLE);

endmodule

// ----- design/msk_dp.sv -----
// msk_dp: stack memories, top and running-maximum registers, output register
// depends on msk_pkg; commanded by msk_ctrl
module msk_dp #(
    parameter int STACK_DEPTH = msk_pkg::MSK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  msk_pkg::t_dp_cmd                  i_cmd,
    output msk_pkg::t_dp_stat                 o_stat,
    input  logic [msk_pkg::REQ_W-1:0]         i_req,
    input  logic [msk_pkg::IN_DATA_W-1:0]     i_data,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [msk_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [msk_pkg::ST_W-1:0]          o_m_tuser
);
    import msk_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // stack memories
    logic signed [VAL_W-1:0] r_val_mem [STACK_DEPTH];
    logic        [AW-1:0]    r_idx_mem [STACK_DEPTH];
    logic signed [VAL_W-1:0] r_rd_val;
    logic        [AW-1:0]    r_rd_idx;

    // working registers
    t_req                    r_req,     n_req;
    logic signed [VAL_W-1:0] r_pval,    n_pval;
    logic        [CW-1:0]    r_count,   n_count;
    logic signed [VAL_W-1:0] r_top,     n_top;
    logic        [AW-1:0]    r_max_pos, n_max_pos;
    logic signed [VAL_W-1:0] r_max_val, n_max_val;
    logic signed [VAL_W-1:0] r_removed, n_removed;
    t_status                 r_status,  n_status;
    logic        [AW-1:0]    r_idx,     n_idx;

    // output register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_removed;
    logic signed [VAL_W-1:0] r_out_top;
    logic signed [VAL_W-1:0] r_out_max;
    logic [CNT_OUT_W-1:0]    r_out_count;
    t_status                 r_out_status;

    // link and memory port signals
    logic        [AW-1:0]    w_lk_pos;
    logic signed [VAL_W-1:0] w_lk_val;
    logic                    w_take;
    logic        [AW-1:0]    w_link;
    logic                    w_we;
    logic        [AW-1:0]    w_raddr;
    logic        [CW-1:0]    w_cnt_m2;
    logic [CW+CNT_OUT_W-1:0] w_cnt_ext;
    logic                    w_out_free;

    // new entry position and value for the max-index rule
    always_comb begin
        if (i_cmd.op == OP_WALK_WR) begin
            w_lk_pos = r_idx;
            w_lk_val = r_rd_val;
        end else begin
            w_lk_pos = r_count[AW-1:0];
            w_lk_val = r_pval;
        end
    end

    // newer entry wins a tie, the bottom entry always links to itself
    assign w_take   = (w_lk_pos == '0) || !(w_lk_val < r_max_val);
    assign w_link   = w_take ? w_lk_pos : r_max_pos;
    assign w_cnt_m2 = r_count - CW'(2);

    // operation decode
    always_comb begin
        n_req     = r_req;
        n_pval    = r_pval;
        n_count   = r_count;
        n_top     = r_top;
        n_max_pos = r_max_pos;
        n_max_val = r_max_val;
        n_removed = r_removed;
        n_status  = r_status;
        n_idx     = r_idx;
        w_we      = 1'b0;
        w_raddr   = '0;
        unique case (i_cmd.op)
            OP_LATCH: begin
                n_req     = t_req'(i_req);
                n_pval    = i_data;
                n_removed = '0;
                n_status  = ST_OK;
            end
            OP_PUSH: begin
                w_we    = 1'b1;
                n_count = r_count + CW'(1);
                n_top   = r_pval;
                if (w_take) begin
                    n_max_pos = w_lk_pos;
                    n_max_val = r_pval;
                end
            end
            OP_ERR_EMPTY: n_status = ST_EMPTY;
            OP_ERR_FULL:  n_status = ST_FULL;
            OP_POP: begin
                n_removed = r_top;
                n_count   = r_count - CW'(1);
                w_raddr   = w_cnt_m2[AW-1:0];
                if (r_count == CW'(1)) begin
                    n_top     = '0;
                    n_max_val = '0;
                    n_max_pos = '0;
                end
            end
            OP_POP_TOP: begin
                n_top     = r_rd_val;
                n_max_pos = r_rd_idx;
                w_raddr   = r_rd_idx;
            end
            OP_POP_MAXV: n_max_val = r_rd_val;
            OP_PM_START: begin
                n_removed = r_max_val;
                n_idx     = r_max_pos;
                w_raddr   = r_max_pos - AW'(1);
            end
            OP_PM_IDX: begin
                n_max_pos = r_rd_idx;
                w_raddr   = r_rd_idx;
            end
            OP_PM_VAL: n_max_val = r_rd_val;
            OP_WALK_RD: w_raddr = r_idx + AW'(1);
            OP_WALK_WR: begin
                w_we  = 1'b1;
                n_idx = r_idx + AW'(1);
                if (w_take) begin
                    n_max_pos = r_idx;
                    n_max_val = r_rd_val;
                end
                if (o_stat.walk_last) begin
                    n_count = r_count - CW'(1);
                    n_top   = r_rd_val;
                end
            end
            OP_NONE: n_idx = r_idx;
            default: n_idx = r_idx;
        endcase
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_val_mem[w_lk_pos] <= w_lk_val;
            r_idx_mem[w_lk_pos] <= w_link;
        end
        r_rd_val <= r_val_mem[w_raddr];
        r_rd_idx <= r_idx_mem[w_raddr];
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_top     <= '0;
            r_max_pos <= '0;
            r_max_val <= '0;
        end else begin
            r_count   <= n_count;
            r_top     <= n_top;
            r_max_pos <= n_max_pos;
            r_max_val <= n_max_val;
        end
        r_req     <= n_req;
        r_pval    <= n_pval;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_idx     <= n_idx;
    end

    // result beat register, loaded from the settled next values
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_cnt_ext  = {{CNT_OUT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_removed <= n_removed;
            r_out_top     <= n_top;
            r_out_max     <= n_max_val;
            r_out_count   <= w_cnt_ext[CNT_OUT_W-1:0];
            r_out_status  <= n_status;
        end
    end

    // status to the controller
    assign o_stat.req          = r_req;
    assign o_stat.empty        = (r_count == '0);
    assign o_stat.full         = (r_count == CW'(STACK_DEPTH));
    assign o_stat.one_left     = (r_count == CW'(1));
    assign o_stat.max_at_top   = (CW'(r_max_pos) + CW'(1) == r_count);
    assign o_stat.max_pos_zero = (r_max_pos == '0);
    assign o_stat.walk_last    = (CW'(r_idx) + CW'(2) == r_count);
    assign o_stat.out_free     = w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out_count, r_out_max, r_out_top, r_out_removed};
    assign o_m_tuser  = r_out_status;

endmodule

// ----- design/max_stack_engine.sv -----
// max_stack_engine: push, pop and pop-max of signed words, one result beat per request
// pop reloads the top and maximum from memory unless it takes the last entry; pop-max as pop
// when the maximum is on top, else it reloads the maximum and moves each entry above it down
// one request at a time, set by the single read port of the value and max-index memories
// a new request is taken while the previous result beat waits, then holds until it is taken
// reset (synchronous, active low) empties the stack; memories are not cleared
module max_stack_engine #(
    parameter int STACK_DEPTH = msk_pkg::MSK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // push_value
    input  logic [msk_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic [msk_pkg::REQ_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // removed_value, top_value, max_value, entry_count, zero pad
    output logic [msk_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // status
    output logic [msk_pkg::ST_W-1:0]       o_m_tuser
);
    import msk_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller
    msk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    msk_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_req      (i_s_tuser),
        .i_data     (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef SYNTH
    // one request at a time: ready drops after an accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    // an error result removes nothing
    a_err_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_OK)) |-> (o_m_tdata[VAL_W-1:0] == '0))
        else $error("error result carries a removed value");

    // an empty error reports an empty stack
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_EMPTY))
        |-> (o_m_tdata[3*VAL_W+CNT_OUT_W-1:VAL_W] == '0))
        else $error("empty error with non-zero top, maximum or count");

    // a result never appears without a prior command to load it
    a_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_cmd.out_load))
        else $error("result beat raised without a load");
`endif

endmodule

// ----- bench/msk_checker.sv -----
// msk_checker: watches both stream channels of max_stack_engine, predicts each result beat
// from the accepted request beats and compares them field by field
// depends on msk_pkg for widths, request kinds and status codes
module msk_checker #(
    parameter int STACK_DEPTH = msk_pkg::MSK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // push_value
    input  logic [msk_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic [msk_pkg::REQ_W-1:0]      i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // removed_value, top_value, max_value, entry_count, zero pad
    input  logic [msk_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // status
    input  logic [msk_pkg::ST_W-1:0]       i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import msk_pkg::*;

    // one predicted result beat
    typedef struct packed {
        logic [VAL_W-1:0]     removed;
        logic [VAL_W-1:0]     top_val;
        logic [VAL_W-1:0]     peak_val;
        logic [CNT_OUT_W-1:0] count;
        t_status              status;
    } t_result;

    // shadow stack, bottom entry at index 0
    logic signed [VAL_W-1:0] stack_vals [STACK_DEPTH];
    int                      stack_fill;
    t_result                 result_q [$];
    int                      fail_cnt    = 0;
    int                      pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    // position of the greatest entry, ties going to the one nearer the top
    function automatic int peak_position();
        int best;
        best = 0;
        for (int i = 1; i < stack_fill; i++) begin
            if (stack_vals[i] >= stack_vals[best]) begin
                best = i;
            end
        end
        return best;
    endfunction

    // apply one request to the shadow stack and build its result
    function automatic t_result apply_request(t_req kind, logic signed [VAL_W-1:0] val);
        t_result r;
        int      pos;
        r        = '0;
        r.status = ST_OK;
        case (kind)
            REQ_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_vals[stack_fill] = val;
                    stack_fill++;
                end
            end
            REQ_POP: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stack_fill--;
                    r.removed = stack_vals[stack_fill];
                end
            end
            REQ_POPMAX: begin
                if (stack_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos       = peak_position();
                    r.removed = stack_vals[pos];
                    // close the gap left by the removed entry
                    for (int i = pos; i < stack_fill - 1; i++) begin
                        stack_vals[i] = stack_vals[i + 1];
                    end
                    stack_fill--;
                end
            end
            default: ;
        endcase
        if (stack_fill > 0) begin
            r.top_val  = stack_vals[stack_fill - 1];
            r.peak_val = stack_vals[peak_position()];
        end
        r.count = CNT_OUT_W'(stack_fill);
        return r;
    endfunction

    function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
        if (want !== got) begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                     $time, name, $signed(want), want, $signed(got), got);
        end
    endfunction

    // result beats are checked before the request beat of the same edge is queued
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            stack_fill = 0;
            result_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (result_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result beat with nothing expected, actual tdata 0x%h tuser %0d",
                             $time, i_m_tdata, i_m_tuser);
                end else begin
                    want = result_q.pop_front();
                    check_field("removed_value", want.removed, i_m_tdata[VAL_W-1:0]);
                    check_field("top_value", want.top_val, i_m_tdata[2*VAL_W-1:VAL_W]);
                    check_field("max_value", want.peak_val, i_m_tdata[3*VAL_W-1:2*VAL_W]);
                    check_field("entry_count", VAL_W'(want.count),
                                VAL_W'(i_m_tdata[3*VAL_W+CNT_OUT_W-1:3*VAL_W]));
                    check_field("tdata pad", '0,
                                VAL_W'(i_m_tdata[OUT_DATA_W-1:OUT_DATA_W-OUT_PAD_W]));
                    check_field("status", VAL_W'(want.status), VAL_W'(i_m_tuser));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                result_q.insert(result_q.size(),
                                apply_request(t_req'(i_s_tuser), i_s_tdata));
            end
        end
        pending_cnt = result_q.size();
    end

endmodule

// ----- bench/tb_max_stack_engine.sv -----
// tb_max_stack_engine: clock, reset and request stimulus for max_stack_engine, with
// random idling on both channels; checking is left to msk_checker
// depends on msk_pkg, max_stack_engine and msk_checker
module tb_max_stack_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import msk_pkg::*;

    localparam int DEPTH          = MSK_DEPTH_DEF;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0]      s_tuser  = REQ_PUSH;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [ST_W-1:0]       m_tuser;
    int                    fail_count;
    int                    pending;

    // shared between the sender and the receiver
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;

    // stimulus bookkeeping
    int stim_depth = 0;
    int peak_depth = 0;
    int n_push = 0, n_pop = 0, n_popmax = 0, n_none = 0, n_full = 0, n_empty = 0;
    int stall_cycles = 0;
    int full_extra;

    always #5 clk = ~clk;

    max_stack_engine #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    msk_checker #(
        .STACK_DEPTH(DEPTH)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // value mix: full range, a narrow band for ties, and the extremes
    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return $urandom();
        end else if (sel < 8) begin
            return VAL_W'($signed($urandom_range(0, 8)) - 4);
        end
        case ($urandom_range(0, 3))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // weighted request kind, the remainder going to the unused selector
    function automatic t_req pick_kind(int push_w, int pop_w, int popmax_w);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_w) return REQ_PUSH;
        if (roll < push_w + pop_w) return REQ_POP;
        if (roll < push_w + pop_w + popmax_w) return REQ_POPMAX;
        return REQ_NONE;
    endfunction

    // offer one request beat and wait for it to be taken
    task automatic send_beat(input t_req kind, input logic [VAL_W-1:0] val);
        while (!no_idle && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= val;
        do @(posedge clk); while (!s_tready);
        // occupancy used only to steer the stimulus
        case (kind)
            REQ_PUSH: begin
                n_push++;
                if (stim_depth < DEPTH) stim_depth++;
                else n_full++;
            end
            REQ_POP, REQ_POPMAX: begin
                if (kind == REQ_POP) n_pop++;
                else n_popmax++;
                if (stim_depth > 0) stim_depth--;
                else n_empty++;
            end
            default: n_none++;
        endcase
        if (stim_depth > peak_depth) peak_depth = stim_depth;
    endtask

    // sender pause until every result beat is back, sampled clear of the rising edge
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin : receiver
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 28);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : sender
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty removals, extremes, ties and both pop-max positions
        send_beat(REQ_POP, 32'h0);
        send_beat(REQ_POPMAX, 32'hffff_ffff);
        send_beat(REQ_NONE, 32'h5a5a_a5a5);
        send_beat(REQ_PUSH, 32'h7fff_ffff);
        send_beat(REQ_PUSH, 32'h8000_0000);
        send_beat(REQ_PUSH, 32'h0000_0000);
        send_beat(REQ_PUSH, 32'hffff_ffff);
        send_beat(REQ_PUSH, 32'h7fff_ffff);
        send_beat(REQ_NONE, 32'ha5a5_5a5a);
        send_beat(REQ_POPMAX, 32'h0);
        send_beat(REQ_POPMAX, 32'h0);
        send_beat(REQ_PUSH, 32'd5);
        send_beat(REQ_PUSH, 32'd5);
        send_beat(REQ_PUSH, 32'd3);
        send_beat(REQ_POPMAX, 32'h0);
        send_beat(REQ_POP, 32'h0);
        send_beat(REQ_POP, 32'h0);
        send_beat(REQ_POPMAX, 32'h0);
        send_beat(REQ_POPMAX, 32'h0);
        send_beat(REQ_POP, 32'h0);
        send_beat(REQ_POP, 32'h0);
        wait_drained();

        // balanced random traffic, with a long receiver hold-off and a no-idle stretch
        for (int n = 0; n < 320; n++) begin
            if (n == 40) hold_req = 1'b1;
            if (n == 120) no_idle = 1'b1;
            if (n == 260) no_idle = 1'b0;
            send_beat(pick_kind(45, 20, 25), pick_value());
        end

        // fill to the top, then push against the full stack
        full_extra = 0;
        while (full_extra < 3) begin
            if (stim_depth == DEPTH) begin
                full_extra++;
                send_beat(REQ_PUSH, pick_value());
            end else begin
                send_beat(pick_kind(96, 1, 2), pick_value());
            end
        end
        send_beat(REQ_POPMAX, pick_value());
        send_beat(REQ_PUSH, pick_value());
        send_beat(REQ_PUSH, pick_value());

        // removal-heavy traffic on the deep stack
        for (int n = 0; n < 200; n++) begin
            send_beat(pick_kind(5, 45, 45), pick_value());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0) begin
            $display("%0d expected results never arrived", pending);
        end
        $display("requests: %0d push (%0d on a full stack), %0d pop, %0d pop-max, %0d no-op",
                 n_push, n_full, n_pop, n_popmax, n_none);
        $display("removals on an empty stack: %0d, deepest stack: %0d of %0d",
                 n_empty, peak_depth, DEPTH);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/msk_pkg.sv
design/msk_ctrl.sv
design/msk_dp.sv
design/max_stack_engine.sv
bench/msk_checker.sv
bench/tb_max_stack_engine.sv
